[src/plc_pkg.sv]
// Shared types and constants of the per-line distinct id counter.
package plc_pkg;

  localparam int unsigned ItemIdW    = 16;
  localparam int unsigned LineCountW = 8;
  localparam int unsigned LinesDoneW = 16;

  localparam logic KIND_ID  = 1'b0;
  localparam logic KIND_EOL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_WALK,
    ST_EOL
  } ctl_state_e;

  typedef struct packed {
    logic clr_step;
    logic take;
    logic commit;
    logic walk_rd;
    logic eol_fin;
  } plc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_end;
    logic walk_pend;
    logic out_free;
  } plc_sts_t;

endpackage

[src/plc_in_if.sv]
// Input channel: id occurrences and end-of-line markers.
interface plc_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [plc_pkg::ItemIdW-1:0]        item_id;

  modport source (output valid, output kind, output item_id, input ready);
  modport sink   (input valid, input kind, input item_id, output ready);
endinterface

[src/plc_out_if.sv]
// Output channel: one result per input item.
interface plc_out_if;
  logic                               valid;
  logic                               ready;
  logic [plc_pkg::LineCountW-1:0]     line_count;
  logic                               first_in_line;
  logic                               bad_id;
  logic [plc_pkg::LinesDoneW-1:0]     lines_done;

  modport source (output valid, output line_count, output first_in_line, output bad_id,
                  output lines_done, input ready);
  modport sink   (input valid, input line_count, input first_in_line, input bad_id,
                  input lines_done, output ready);
endinterface

[src/plc_ctrl.sv]
// Controller state machine: clearing sweep, id lookup, seen-list walk.
module plc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  output logic               in_ready_o,
  input  plc_pkg::plc_sts_t  sts_i,
  output plc_pkg::plc_cmd_t  cmd_o
);

  plc_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      plc_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = plc_pkg::ST_IDLE;
        end
      end
      plc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = (in_kind_i == plc_pkg::KIND_EOL) ? plc_pkg::ST_WALK : plc_pkg::ST_LOOK;
        end
      end
      plc_pkg::ST_LOOK: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = plc_pkg::ST_IDLE;
        end
      end
      plc_pkg::ST_WALK: begin
        cmd_o.walk_rd = !sts_i.walk_end;
        // leave once the last mark clear has been written
        if (sts_i.walk_end && !sts_i.walk_pend) begin
          state_d = plc_pkg::ST_EOL;
        end
      end
      plc_pkg::ST_EOL: begin
        if (sts_i.out_free) begin
          cmd_o.eol_fin = 1'b1;
          state_d       = plc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = plc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

[src/plc_datapath.sv]
// Datapath: mark, count and seen-list memories, counters and result register.
module plc_datapath #(
  parameter int unsigned ID_SPACE  = 65536,
  parameter int unsigned COUNT_MAX = 255
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [plc_pkg::ItemIdW-1:0]       in_item_id_i,
  input  plc_pkg::plc_cmd_t                 cmd_i,
  output plc_pkg::plc_sts_t                 sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [plc_pkg::LineCountW-1:0]    out_line_count_o,
  output logic                              out_first_o,
  output logic                              out_bad_o,
  output logic [plc_pkg::LinesDoneW-1:0]    out_lines_done_o
);

  localparam int unsigned IdxW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
  localparam int unsigned CntW = $clog2(COUNT_MAX + 1);
  localparam int unsigned LenW = IdxW + 1;

  logic            mark_mem [ID_SPACE];
  logic [CntW-1:0] cnt_mem  [ID_SPACE];
  logic [IdxW-1:0] list_mem [ID_SPACE];

  logic [IdxW-1:0] clr_idx_q;
  logic [IdxW-1:0] id_q;
  logic            ok_q;
  logic            mark_rd_q;
  logic [CntW-1:0] cnt_rd_q;
  logic [LenW-1:0] len_q;
  logic [LenW-1:0] walk_idx_q;
  logic [IdxW-1:0] list_rd_q;
  logic            pend_q;
  logic [plc_pkg::LinesDoneW-1:0] total_q;

  logic            out_valid_q;
  logic [plc_pkg::LineCountW-1:0] out_cnt_q;
  logic            out_first_q;
  logic            out_bad_q;
  logic [plc_pkg::LinesDoneW-1:0] out_done_q;

  logic [IdxW-1:0] in_idx;
  logic            in_ok;
  logic            first;
  logic [CntW-1:0] new_cnt;
  logic            list_room;
  logic            out_free;
  logic            mark_we;
  logic [IdxW-1:0] mark_wa;
  logic            mark_wd;
  logic            cnt_we;
  logic [IdxW-1:0] cnt_wa;
  logic [CntW-1:0] cnt_wd;
  logic [plc_pkg::LinesDoneW-1:0] total_inc;

  assign in_idx    = IdxW'(in_item_id_i);
  assign in_ok     = (in_item_id_i != '0) && (32'(in_item_id_i) < 32'(ID_SPACE));
  assign first     = ok_q && !mark_rd_q;
  assign new_cnt   = (first && (cnt_rd_q < CntW'(COUNT_MAX))) ? cnt_rd_q + 1'b1 : cnt_rd_q;
  assign list_room = len_q < LenW'(ID_SPACE);
  assign out_free  = !out_valid_q || out_ready_i;
  assign total_inc = total_q + 1'b1;

  // one write port each for the mark and count memories: sweep and commit share both, the walk uses the mark port
  always_comb begin
    mark_we = 1'b0;
    mark_wa = id_q;
    mark_wd = 1'b1;
    cnt_we  = 1'b0;
    cnt_wa  = id_q;
    cnt_wd  = new_cnt;
    priority if (cmd_i.clr_step) begin
      mark_we = 1'b1;
      mark_wa = clr_idx_q;
      mark_wd = 1'b0;
      cnt_we  = 1'b1;
      cnt_wa  = clr_idx_q;
      cnt_wd  = '0;
    end else if (cmd_i.commit) begin
      mark_we = first;
      cnt_we  = first;
    end else if (pend_q) begin
      mark_we = 1'b1;
      mark_wa = list_rd_q;
      mark_wd = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (cmd_i.take) begin
      mark_rd_q <= mark_mem[in_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd_i.take) begin
      cnt_rd_q <= cnt_mem[in_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && first && list_room) begin
      list_mem[len_q[IdxW-1:0]] <= id_q;
    end
    if (cmd_i.walk_rd) begin
      list_rd_q <= list_mem[walk_idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      id_q <= in_idx;
      ok_q <= in_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      len_q      <= '0;
      walk_idx_q <= '0;
      pend_q     <= 1'b0;
      total_q    <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (cmd_i.commit && first && list_room) begin
        len_q <= len_q + 1'b1;
      end
      if (cmd_i.walk_rd) begin
        walk_idx_q <= walk_idx_q + 1'b1;
      end
      pend_q <= cmd_i.walk_rd;
      if (cmd_i.eol_fin) begin
        len_q      <= '0;
        walk_idx_q <= '0;
        total_q    <= total_inc;
      end
    end
  end

  // result register: load on commit or end of line, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.eol_fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_cnt_q   <= ok_q ? plc_pkg::LineCountW'(new_cnt) : '0;
      out_first_q <= first;
      out_bad_q   <= !ok_q;
      out_done_q  <= total_q;
    end else if (cmd_i.eol_fin) begin
      out_cnt_q   <= '0;
      out_first_q <= 1'b0;
      out_bad_q   <= 1'b0;
      out_done_q  <= total_inc;
    end
  end

  assign sts_o.clr_last  = (clr_idx_q == IdxW'(ID_SPACE - 1));
  assign sts_o.walk_end  = (walk_idx_q == len_q);
  assign sts_o.walk_pend = pend_q;
  assign sts_o.out_free  = out_free;

  assign out_valid_o      = out_valid_q;
  assign out_line_count_o = out_cnt_q;
  assign out_first_o      = out_first_q;
  assign out_bad_o        = out_bad_q;
  assign out_lines_done_o = out_done_q;

endmodule

[src/per_line_distinct_id_counter.sv]
// Per-line distinct id counter: counts, per id, the lines in which it appears.
//
// in_i carries items: kind 0 is an id occurrence, kind 1 ends the current line.
// out_o returns one result per item: the id's saturating line count, whether
// this was the id's first sighting on the line, a bad-id flag (id zero or not
// below ID_SPACE; no state changes) and the number of completed lines.
// An id item's transfer edge does the registered read of the mark and count
// memories; a later edge does the update and loads the result register once
// the output register is free, and only then can the next item be taken.
// An end-of-line item loads its result after the walk, once the output
// register is free: the walk reads one seen-list entry and clears one mark per
// cycle over the single memory ports.
// One item is in flight at a time; a new item is taken while the previous
// result still waits in the output register.
// After reset the block sweeps the mark and count memories, one entry per
// cycle, over all ID_SPACE entries, and keeps in_i.ready low during that sweep.
// When the receiver stalls, the result holds in the output register and the
// next item stops before its update until the register frees up.
module per_line_distinct_id_counter #(
  parameter int unsigned ID_SPACE  = 65536,
  parameter int unsigned COUNT_MAX = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  plc_in_if.sink    in_i,
  plc_out_if.source out_o
);

  plc_pkg::plc_cmd_t cmd;
  plc_pkg::plc_sts_t sts;

  plc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plc_datapath #(
    .ID_SPACE  (ID_SPACE),
    .COUNT_MAX (COUNT_MAX)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_item_id_i     (in_i.item_id),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_line_count_o (out_o.line_count),
    .out_first_o      (out_o.first_in_line),
    .out_bad_o        (out_o.bad_id),
    .out_lines_done_o (out_o.lines_done)
  );

  // one item in flight: no transfer in the cycle after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken twice in a row");

  // a rejected id reports neither a count nor a first sighting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_id) |-> (!out_o.first_in_line && out_o.line_count == '0))
    else $error("bad id with nonzero result");

  // a result appears only in the cycle after an update command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_o.valid)) |-> $past(cmd.commit || cmd.eol_fin))
    else $error("result without update");

endmodule

[sim/plc_line_tally_checker.sv]
// Checker for the per-line distinct id counter: predicts each result and compares.
module plc_line_tally_checker #(
  parameter int unsigned ID_SPACE  = 65536,
  parameter int unsigned COUNT_MAX = 255
) (
  input  logic clk_i,
  input  logic rst_ni,
  plc_in_if    in_mon_i,
  plc_out_if   out_mon_i,
  output int   mismatches_o,
  output int   owed_o
);

  typedef struct packed {
    logic [plc_pkg::LineCountW-1:0] line_count;
    logic                           first_in_line;
    logic                           bad_id;
    logic [plc_pkg::LinesDoneW-1:0] lines_done;
  } line_tally_t;

  bit                             line_marks [ID_SPACE];
  int unsigned                    id_hits    [ID_SPACE];
  logic [plc_pkg::ItemIdW-1:0]    listed_ids [$];
  logic [plc_pkg::LinesDoneW-1:0] lines_closed;
  line_tally_t                    owed_results [$];

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (mismatches_o < 30) begin
      $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    end
    mismatches_o++;
  endtask

  // Update the line state for one item and return the result it should give.
  function automatic line_tally_t tally_item(input logic kind,
                                             input logic [plc_pkg::ItemIdW-1:0] id);
    line_tally_t r;
    r = '0;
    if (kind == plc_pkg::KIND_EOL) begin
      foreach (listed_ids[k]) line_marks[listed_ids[k]] = 1'b0;
      listed_ids.delete();
      lines_closed = lines_closed + 1'b1;
    end else if (id == '0 || 32'(id) >= ID_SPACE) begin
      r.bad_id = 1'b1;
    end else begin
      if (!line_marks[id]) begin
        line_marks[id] = 1'b1;
        if (listed_ids.size() < ID_SPACE) listed_ids.insert(listed_ids.size(), id);
        if (id_hits[id] < COUNT_MAX) id_hits[id]++;
        r.first_in_line = 1'b1;
      end
      r.line_count = id_hits[id][plc_pkg::LineCountW-1:0];
    end
    r.lines_done = lines_closed;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    line_tally_t got;
    line_tally_t want;
    if (!rst_ni) begin
      for (int unsigned a = 0; a < ID_SPACE; a++) begin
        line_marks[a] = 1'b0;
        id_hits[a]    = 0;
      end
      listed_ids.delete();
      owed_results.delete();
      lines_closed = '0;
    end else begin
      // Retire the result first: it always belongs to an earlier transfer.
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.line_count    = out_mon_i.line_count;
        got.first_in_line = out_mon_i.first_in_line;
        got.bad_id        = out_mon_i.bad_id;
        got.lines_done    = out_mon_i.lines_done;
        if (owed_results.size() == 0) begin
          flag_mismatch("result with nothing owed, lines_done", got.lines_done, 0);
        end else begin
          want = owed_results.pop_front();
          if (got.line_count !== want.line_count)
            flag_mismatch("line_count", got.line_count, want.line_count);
          if (got.first_in_line !== want.first_in_line)
            flag_mismatch("first_in_line", got.first_in_line, want.first_in_line);
          if (got.bad_id !== want.bad_id)
            flag_mismatch("bad_id", got.bad_id, want.bad_id);
          if (got.lines_done !== want.lines_done)
            flag_mismatch("lines_done", got.lines_done, want.lines_done);
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        owed_results.insert(owed_results.size(),
                            tally_item(in_mon_i.kind, in_mon_i.item_id));
      end
    end
    owed_o = owed_results.size();
  end

endmodule

[sim/per_line_distinct_id_counter_test.sv]
// Top of the per-line distinct id counter regression: stimulus, idling and verdict.
module per_line_distinct_id_counter_test;

  localparam int unsigned IdSpace     = 65536;
  localparam int unsigned CountMax    = 255;
  localparam int unsigned RandomItems = 1250;
  localparam int unsigned HotLines    = 230;
  localparam int unsigned LongSpan    = 120;
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam logic [plc_pkg::ItemIdW-1:0] HotId = 16'hC3A5;

  logic        clk_i;
  logic        rst_ni;
  int          mismatch_total;
  int          results_owed;
  bit          idle_on;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned items_sent;
  int unsigned hot_lines;
  int unsigned cycle_count;

  plc_in_if  in_ch ();
  plc_out_if out_ch ();

  per_line_distinct_id_counter #(
    .ID_SPACE (IdSpace),
    .COUNT_MAX(CountMax)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  plc_line_tally_checker #(
    .ID_SPACE (IdSpace),
    .COUNT_MAX(CountMax)
  ) tally_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .mismatches_o(mismatch_total),
    .owed_o      (results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("per_line_distinct_id_counter regression: fail");
    $finish;
  end

  // Receiver: stall in random bursts while idling is on.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic kind, input logic [plc_pkg::ItemIdW-1:0] id);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(99) < send_gap_pct) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      in_ch.valid   <= 1'b0;
      in_ch.kind    <= 1'($urandom());
      in_ch.item_id <= 16'($urandom());
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.item_id <= id;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    items_sent++;
    // Change the idling mix now and then, including stretches with none.
    if (idle_on && items_sent % 40 == 0) begin
      send_gap_pct = 25 * $urandom_range(2);
      stall_pct    = 25 * $urandom_range(2);
    end
  endtask

  // One line: span ids, many from a small pool, optionally the hot id, then end of line.
  task automatic send_line(input int unsigned span, input bit with_hot);
    int unsigned hot_at;
    int unsigned roll;
    logic [plc_pkg::ItemIdW-1:0] id;
    hot_at = $urandom_range(span);
    for (int unsigned k = 0; k <= span; k++) begin
      if (with_hot && k == hot_at) send_item(plc_pkg::KIND_ID, HotId);
      if (k < span) begin
        roll = $urandom_range(99);
        if (roll < 8) id = '0;
        else if (roll < 55) id = 16'($urandom_range(1, 24));
        else if (roll < 65) id = HotId;
        else id = 16'($urandom());
        send_item(plc_pkg::KIND_ID, id);
      end
    end
    send_item(plc_pkg::KIND_EOL, 16'($urandom()));
    if (with_hot) hot_lines++;
  endtask

  initial begin
    int unsigned random_end;
    in_ch.valid   = 1'b0;
    in_ch.kind    = plc_pkg::KIND_ID;
    in_ch.item_id = '0;
    rst_ni        = 1'b0;
    idle_on       = 1'b1;
    send_gap_pct  = 25;
    stall_pct     = 25;
    items_sent    = 0;
    hot_lines     = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: repeats on a line, id zero, extreme ids, ignored id on end of
    // line, empty lines and back-to-back ends of line.
    send_item(plc_pkg::KIND_ID,  16'h0001);
    send_item(plc_pkg::KIND_ID,  16'h0001);
    send_item(plc_pkg::KIND_ID,  16'h0000);
    send_item(plc_pkg::KIND_ID,  16'hFFFF);
    send_item(plc_pkg::KIND_ID,  16'h8000);
    send_item(plc_pkg::KIND_ID,  16'hFFFF);
    send_item(plc_pkg::KIND_EOL, 16'hABCD);
    send_item(plc_pkg::KIND_EOL, 16'h0000);
    send_item(plc_pkg::KIND_ID,  16'h0001);
    send_item(plc_pkg::KIND_ID,  16'h0000);
    send_item(plc_pkg::KIND_ID,  16'h7FFF);
    send_item(plc_pkg::KIND_ID,  16'h0001);
    send_item(plc_pkg::KIND_EOL, 16'hFFFF);
    send_item(plc_pkg::KIND_ID,  16'h5555);
    send_item(plc_pkg::KIND_ID,  16'hAAAA);
    send_item(plc_pkg::KIND_ID,  16'h5555);
    send_item(plc_pkg::KIND_EOL, 16'h0000);
    send_item(plc_pkg::KIND_EOL, 16'h1234);
    send_item(plc_pkg::KIND_ID,  16'h0000);
    send_item(plc_pkg::KIND_ID,  16'hFFFF);
    send_item(plc_pkg::KIND_EOL, 16'h8001);

    // Random short lines; the hot id rides in most lines so its count saturates.
    random_end = items_sent + RandomItems;
    while (items_sent < random_end || hot_lines < HotLines) begin
      send_line($urandom_range(0, 5), $urandom_range(19) != 0);
    end

    // Two long lines over the same ids: the second proves the walk cleared the marks.
    repeat (2) begin
      for (int unsigned k = 0; k < LongSpan; k++) begin
        send_item(plc_pkg::KIND_ID, 16'(16'h0100 + k));
      end
      send_item(plc_pkg::KIND_ID, 16'h0100);
      send_item(plc_pkg::KIND_EOL, 16'($urandom()));
    end

    // Last part without idling: more lines with the hot id past saturation.
    idle_on      = 1'b0;
    send_gap_pct = 0;
    stall_pct    = 0;
    repeat (50) send_line($urandom_range(0, 9), 1'b1);
    in_ch.valid <= 1'b0;

    while (results_owed != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("per_line_distinct_id_counter regression: pass");
    end else begin
      $display("per_line_distinct_id_counter regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/plc_pkg.sv
src/plc_in_if.sv
src/plc_out_if.sv
src/plc_ctrl.sv
src/plc_datapath.sv
src/per_line_distinct_id_counter.sv
sim/plc_line_tally_checker.sv
sim/per_line_distinct_id_counter_test.sv
